// ===== rtl/core/bpd_pkg.sv =====
package bpd_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int NUM_EVENTS  = 4;
	localparam int LANE_W      = 2;
	localparam int EVT_W       = 2;
	localparam int COUNT_W     = 8;
	localparam int WORD_W      = 11;
	localparam int OP_W        = 3;
	localparam int REG_IDX_W   = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	localparam int THR_LSB    = 0;
	localparam int BTN_LSB    = 8;
	localparam int EVT_IN_USE = 10;

	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_LOCK    = 3'd1;
	localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd2;
	localparam logic [OP_W-1:0] OP_ENABLE  = 3'd3;
	localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_BUTTONS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_EVENT_0 = 3'd1;

	typedef struct packed {
		logic               tick;
		logic               lock;
		logic               unlock;
		logic [COUNT_W-1:0] dur;
	} item_cmd_t;

	typedef struct packed {
		logic               release_hit;
		logic               held;
		logic               locked;
		logic [COUNT_W-1:0] count;
	} lane_stat_t;

endpackage

// ===== rtl/core/bpd_if.sv =====
interface bpd_item_if;
	import bpd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [OP_W-1:0]        operation;
	logic [NUM_BUTTONS-1:0] pin_levels;
	logic [LANE_W-1:0]      button_index;
	logic [COUNT_W-1:0]     lock_duration;
	logic [EVT_W-1:0]       event_index;

	modport source(output valid, operation, pin_levels, button_index, lock_duration,
		event_index, input ready);
	modport sink(input valid, operation, pin_levels, button_index, lock_duration,
		event_index, output ready);
endinterface

interface bpd_result_if;
	import bpd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [NUM_EVENTS-1:0]  fired_events;
	logic [NUM_BUTTONS-1:0] pressed_mask;
	logic [NUM_BUTTONS-1:0] locked_mask;

	modport source(output valid, fired_events, pressed_mask, locked_mask, input ready);
	modport sink(input valid, fired_events, pressed_mask, locked_mask, output ready);
endinterface

// ===== rtl/core/bpd_lane.sv =====
module bpd_lane
	import bpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       in_use,
	input  logic       pin,
	input  logic       sel,
	input  item_cmd_t  cmd,
	output lane_stat_t stat
);

	logic               lock_q, fev_q, held_q;
	logic [COUNT_W-1:0] rem_q, cnt_q;
	logic               lock_n, fev_n, held_n, rel;
	logic [COUNT_W-1:0] rem_n, cnt_n;

	always_comb begin
		lock_n = lock_q;
		fev_n  = fev_q;
		held_n = held_q;
		rem_n  = rem_q;
		cnt_n  = cnt_q;
		rel    = 1'b0;
		if (in_use) begin
			if (cmd.tick) begin
				if (lock_q && !fev_q) begin
					if (rem_q != '0)
						rem_n = rem_q - 1'b1;
					if (rem_n == '0)
						lock_n = 1'b0;
				end
				if (pin) begin
					if (!lock_n) begin
						held_n = 1'b1;
						if (cnt_q != COUNT_MAX)
							cnt_n = cnt_q + 1'b1;
					end
				end else if (held_q && !lock_n) begin
					rel    = 1'b1;
					cnt_n  = '0;
					held_n = 1'b0;
				end
			end else if (cmd.lock && sel) begin
				fev_n  = (cmd.dur == '0);
				rem_n  = cmd.dur;
				lock_n = 1'b1;
			end else if (cmd.unlock && sel) begin
				fev_n  = 1'b0;
				rem_n  = '0;
				lock_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= 1'b0;
			fev_q  <= 1'b0;
			held_q <= 1'b0;
			rem_q  <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			lock_q <= lock_n;
			fev_q  <= fev_n;
			held_q <= held_n;
			rem_q  <= rem_n;
			cnt_q  <= cnt_n;
		end
	end

	assign stat.release_hit = rel;
	assign stat.held        = held_n;
	assign stat.locked      = lock_n;
	assign stat.count       = cnt_q;

	a_forever_lock_holds: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q && fev_q && !(accept && in_use && cmd.unlock && sel) |=> lock_q)
		else $error("unbounded lock released without unlock");

	a_release_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		rel |-> held_q && !lock_n && cmd.tick)
		else $error("release on a locked or idle lane");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rel |=> cnt_q == '0 && !held_q)
		else $error("count not cleared after release");

endmodule

// ===== rtl/core/bpd_merge.sv =====
module bpd_merge
	import bpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]     cfg_data,
	input  logic [OP_W-1:0]       operation,
	input  logic [EVT_W-1:0]      event_index,
	input  lane_stat_t            stat [NUM_BUTTONS],
	output logic [NUM_EVENTS-1:0] fired
);

	logic [WORD_W-1:0]     word_q [NUM_EVENTS];
	logic [NUM_EVENTS-1:0] en_q;
	logic [NUM_EVENTS-1:0] cand;
	logic [NUM_BUTTONS-1:0] rel_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_EVENTS; j++)
				word_q[j] <= '0;
		end else if (cfg_we) begin
			for (int j = 0; j < NUM_EVENTS; j++)
				if (cfg_index == REG_EVENT_0 + REG_IDX_W'(j))
					word_q[j] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '1;
		end else if (accept) begin
			case (operation)
				OP_ENABLE:  en_q[event_index] <= 1'b1;
				OP_DISABLE: en_q[event_index] <= 1'b0;
				default:    ;
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_EVENTS; j++)
			cand[j] = word_q[j][EVT_IN_USE] && en_q[j]
				&& stat[word_q[j][BTN_LSB +: LANE_W]].release_hit
				&& (word_q[j][THR_LSB +: COUNT_W] != '0)
				&& (word_q[j][THR_LSB +: COUNT_W]
					<= stat[word_q[j][BTN_LSB +: LANE_W]].count);
	end

	always_comb begin
		for (int j = 0; j < NUM_EVENTS; j++) begin
			fired[j] = cand[j];
			for (int k = 0; k < NUM_EVENTS; k++)
				if (k != j && cand[k]
					&& word_q[k][BTN_LSB +: LANE_W] == word_q[j][BTN_LSB +: LANE_W]
					&& (word_q[k][THR_LSB +: COUNT_W] > word_q[j][THR_LSB +: COUNT_W]
					|| (word_q[k][THR_LSB +: COUNT_W] == word_q[j][THR_LSB +: COUNT_W]
					&& k < j)))
					fired[j] = 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++)
			rel_vec[i] = stat[i].release_hit;
	end

	a_one_per_lane: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(fired) <= $countones(rel_vec))
		else $error("more events fired than lanes released");

	a_fired_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(fired & ~en_q) == '0)
		else $error("disabled event fired");

endmodule

// ===== rtl/core/button_press_duration_events_top.sv =====
// Channel   Dir  Handshake      Payload
// items_in  in   valid/ready    operation, pin_levels, button_index, lock_duration,
//                               event_index
// results   out  valid/ready    fired_events, pressed_mask, locked_mask
// cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
// One item per cycle unless stalled; each gives one result the cycle after accept.
// All four lanes and the event compare settle in the cycle the item is accepted.
// A result sits in the output register; items_in.ready stays high while it is
// free or being taken, so a result left waiting stalls the input.
// Reset: all lane state cleared, events enabled, config registers zero.
module button_press_duration_events_top
	import bpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	bpd_item_if.sink             items_in,
	bpd_result_if.source         results,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic [NUM_BUTTONS-1:0] in_use_q;
	logic                   accept;
	item_cmd_t              cmd;
	lane_stat_t             stat [NUM_BUTTONS];
	logic [NUM_EVENTS-1:0]  fired;
	logic [NUM_BUTTONS-1:0] held_vec, lock_vec;
	logic                   out_valid_q;
	logic [NUM_EVENTS-1:0]  fired_q;
	logic [NUM_BUTTONS-1:0] pressed_q, locked_q;

	assign items_in.ready = !out_valid_q || results.ready;
	assign accept         = items_in.valid && items_in.ready;

	assign cmd.tick   = (items_in.operation == OP_TICK);
	assign cmd.lock   = (items_in.operation == OP_LOCK);
	assign cmd.unlock = (items_in.operation == OP_UNLOCK);
	assign cmd.dur    = items_in.lock_duration;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_use_q <= '0;
		else if (cfg_we && cfg_index == REG_BUTTONS)
			in_use_q <= cfg_data[NUM_BUTTONS-1:0];
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		bpd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.accept (accept),
			.in_use (in_use_q[i]),
			.pin    (items_in.pin_levels[i]),
			.sel    (items_in.button_index == LANE_W'(i)),
			.cmd    (cmd),
			.stat   (stat[i])
		);
		assign held_vec[i] = stat[i].held;
		assign lock_vec[i] = stat[i].locked;
	end

	bpd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (items_in.operation),
		.event_index (items_in.event_index),
		.stat        (stat),
		.fired       (fired)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fired_q   <= cmd.tick ? fired : '0;
			pressed_q <= held_vec;
			locked_q  <= lock_vec;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.fired_events = fired_q;
	assign results.pressed_mask = pressed_q;
	assign results.locked_mask  = locked_q;

	a_no_fire_off_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cmd.tick |=> results.fired_events == '0)
		else $error("events fired on a non-tick item");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> items_in.ready)
		else $error("input stalled with empty output register");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

endmodule
